// ===== hdl/cwa_pkg.sv =====
// Package: shared constants, types and state codes of the centered window average.
`timescale 1ns / 1ps
`default_nettype none

package cwa_pkg;

  // Payload widths fixed by the channel definitions
  localparam int DATA_W           = 32;
  localparam int RADIUS_W         = 5;

  // Defaults for the top-level parameters
  localparam int MAX_RADIUS_DEF   = 31;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // Configuration port
  localparam int CFG_DATA_W       = 32;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_IDX_W        = CFG_ADDR_W - 2;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = CFG_IDX_W'(0);

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_DECIDE,
    ST_DIVIDE,
    ST_SEND
  } cwa_state_t;

  // Commands to the window store
  typedef struct packed {
    logic push;
    logic restart;
  } win_cmd_t;

  // Status of the shared divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// ===== hdl/cwa_if.sv =====
// Interfaces: input sample channel and result channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface cwa_in_if import cwa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample;
  logic                     stream_end;

  modport source (output valid, output sample, output stream_end, input ready);
  modport sink   (input valid, input sample, input stream_end, output ready);
endinterface

interface cwa_out_if import cwa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] average;
  logic                     full_window;
  logic                     run_end;

  modport source (output valid, output average, output full_window, output run_end,
                  input ready);
  modport sink   (input valid, input average, input full_window, input run_end,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/cwa_divider.sv =====
// Shared restoring divider: signed dividend by unsigned divisor, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module cwa_divider import cwa_pkg::*; #(
  parameter int DIVIDEND_W = 38,
  parameter int DIVISOR_W  = 6,
  parameter int QUOT_W     = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic signed [DIVIDEND_W-1:0] dividend,
  input  wire logic        [DIVISOR_W-1:0]  divisor,
  output      div_status_t                  status,
  output      logic signed [QUOT_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    neg_r, neg_nxt;
  logic [DIVIDEND_W-1:0]   mag_r, mag_nxt;
  logic [DIVISOR_W-1:0]    rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]    dsr_r, dsr_nxt;
  logic [QUOT_W-1:0]       quo_r, quo_nxt;

  logic [DIVISOR_W:0]      shifted;
  logic [DIVISOR_W+1:0]    diff;
  logic                    fits;
  logic [DIVIDEND_W-1:0]   q_full;

  // One restoring step: bring down the next dividend bit, try the subtract
  always_comb begin
    shifted = {rem_r, mag_r[DIVIDEND_W-1]};
    diff    = {1'b0, shifted} - (DIVISOR_W+2)'(dsr_r);
    fits    = ~diff[DIVISOR_W+1];
    q_full  = neg_r ? -mag_r : mag_r;
  end

  // Step sequencing
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVIDEND_W);
      neg_nxt  = dividend[DIVIDEND_W-1];
      mag_nxt  = dividend[DIVIDEND_W-1] ? -dividend : dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - CNT_W'(1);
        mag_nxt = {mag_r[DIVIDEND_W-2:0], fits};
        rem_nxt = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      end else begin
        // all bits done: restore the sign, truncation toward zero
        quo_nxt  = q_full[QUOT_W-1:0];
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

endmodule

`default_nettype wire

// ===== hdl/cwa_window.sv =====
// Window store: circular sample delay line in a memory, running window sum, fill count.
`timescale 1ns / 1ps
`default_nettype none

module cwa_window import cwa_pkg::*; #(
  parameter int MAX_RADIUS   = MAX_RADIUS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int LINE_DEPTH  = 2 * MAX_RADIUS + 1,
  localparam int K_W         = $clog2(MAX_RADIUS + 1),
  localparam int WIN_W       = K_W + 1,
  localparam int SUM_W       = SAMPLE_WIDTH + $clog2(LINE_DEPTH)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire win_cmd_t                       cmd,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x,
  input  wire logic        [WIN_W-1:0]        win,
  output      logic signed [SUM_W-1:0]        sum,
  output      logic        [WIN_W-1:0]        seen
);

  localparam int PTR_W = $clog2(LINE_DEPTH);

  logic signed [SAMPLE_WIDTH-1:0] mem [LINE_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] rd_data_r;

  logic [PTR_W-1:0]        wp_r, wp_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [WIN_W-1:0]        seen_r, seen_nxt;

  logic [PTR_W:0]          rd_raw;
  logic [PTR_W-1:0]        rd_idx;
  logic signed [SUM_W-1:0] drop;

  // Slot written win pushes ago
  always_comb begin
    rd_raw = (PTR_W+1)'(wp_r) + (PTR_W+1)'(LINE_DEPTH) - (PTR_W+1)'(win);
    if (rd_raw >= (PTR_W+1)'(LINE_DEPTH)) begin
      rd_idx = PTR_W'(rd_raw - (PTR_W+1)'(LINE_DEPTH));
    end else begin
      rd_idx = rd_raw[PTR_W-1:0];
    end
  end

  // Delay line memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wp_r] <= x;
    end
    rd_data_r <= mem[rd_idx];
  end

  // Slide the window: add the new sample, drop the oldest once full
  always_comb begin
    drop     = (seen_r >= win) ? SUM_W'(rd_data_r) : '0;
    wp_nxt   = wp_r;
    sum_nxt  = sum_r;
    seen_nxt = seen_r;
    if (cmd.restart) begin
      wp_nxt   = '0;
      sum_nxt  = '0;
      seen_nxt = '0;
    end else if (cmd.push) begin
      wp_nxt  = (wp_r == PTR_W'(LINE_DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
      sum_nxt = sum_r + SUM_W'(x) - drop;
      if (seen_r < win) begin
        seen_nxt = seen_r + WIN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      sum_r  <= '0;
      seen_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      sum_r  <= sum_nxt;
      seen_r <= seen_nxt;
    end
  end

  assign sum  = sum_r;
  assign seen = seen_r;

endmodule

`default_nettype wire

// ===== hdl/centered_window_average.sv =====
// Top level: centered moving average over a sample stream with edge flush.
//
// in_chan carries one signed sample and a stream_end flag per transfer. Each
// sample yields the result for the position radius samples behind it (the
// window mean truncated toward zero with full_window set, or -1 with it clear
// near the stream start); a sample with stream_end also yields the trailing
// edge positions as -1 and marks its last result with run_end, then the
// stream starts over. Results leave on out_chan, one transfer each.
// One item is worked at a time; in_chan.ready is high only when the block is
// idle. A full-window result goes from the input transfer through the PUSH,
// DECIDE and DIVIDE states to out_chan.valid, held in DIVIDE by the bit-per-cycle
// divider that divides the window sum by 2k+1; edge results go through PUSH and
// DECIDE only, and each further flush result follows as soon as the last is taken.
// A stalled receiver holds the result in place and the block waits.
// rst_n (synchronous) sets radius to zero and empties the window. Writing
// radius over the APB port also empties the window; write only while idle.
`timescale 1ns / 1ps
`default_nettype none

module centered_window_average import cwa_pkg::*; #(
  parameter int MAX_RADIUS   = MAX_RADIUS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  cwa_in_if.sink                     in_chan,
  cwa_out_if.source                  out_chan,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output      logic [CFG_DATA_W-1:0] prdata,
  output      logic                  pready
);

  localparam int LINE_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int K_W        = $clog2(MAX_RADIUS + 1);
  localparam int WIN_W      = K_W + 1;
  localparam int SUM_W      = SAMPLE_WIDTH + $clog2(LINE_DEPTH);

  cwa_state_t                     state_r, state_nxt;
  logic [RADIUS_W-1:0]            radius_r;
  logic signed [SAMPLE_WIDTH-1:0] x_r, x_nxt;
  logic                           end_r, end_nxt;
  logic                           main_r, main_nxt;
  logic                           full_r, full_nxt;
  logic [K_W-1:0]                 flush_r, flush_nxt;

  logic [K_W-1:0]                 k;
  logic [WIN_W-1:0]               win;
  logic signed [SUM_W-1:0]        win_sum;
  logic [WIN_W-1:0]               seen;
  win_cmd_t                       win_cmd;
  logic                           restart_run;
  logic                           div_start;
  div_status_t                    div_stat;
  logic signed [SAMPLE_WIDTH-1:0] div_quo;

  logic                           cfg_wr;
  logic [CFG_IDX_W-1:0]           reg_idx;
  logic                           wr_radius;

  logic                           emit;
  logic                           full_now;
  logic [K_W-1:0]                 flush_now;
  logic                           last_one;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  always_comb begin
    wr_radius = 1'b0;
    prdata    = '0;
    unique case (reg_idx)
      REG_RADIUS: begin
        wr_radius = cfg_wr;
        prdata    = CFG_DATA_W'(radius_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
    end else if (wr_radius) begin
      radius_r <= pwdata[RADIUS_W-1:0];
    end
  end

  // Effective radius and window size
  assign k   = (radius_r > RADIUS_W'(MAX_RADIUS)) ? K_W'(MAX_RADIUS) : radius_r[K_W-1:0];
  assign win = {k, 1'b1};

  // Window store
  cwa_window #(
    .MAX_RADIUS   (MAX_RADIUS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (win_cmd),
    .x     (x_r),
    .win   (win),
    .sum   (win_sum),
    .seen  (seen)
  );

  // Shared divider
  cwa_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (WIN_W),
    .QUOT_W     (SAMPLE_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (win_sum),
    .divisor  (win),
    .status   (div_stat),
    .quotient (div_quo)
  );

  // Result decisions after the window has moved
  always_comb begin
    emit      = seen > WIN_W'(k);
    full_now  = seen == win;
    flush_now = '0;
    if (end_r) begin
      flush_now = (seen < WIN_W'(k)) ? seen[K_W-1:0] : k;
    end
    last_one  = main_r ? (flush_r == '0) : (flush_r == K_W'(1));
  end

  // Sequencer: next state and outputs
  always_comb begin
    state_nxt       = state_r;
    x_nxt           = x_r;
    end_nxt         = end_r;
    main_nxt        = main_r;
    full_nxt        = full_r;
    flush_nxt       = flush_r;
    in_chan.ready   = 1'b0;
    out_chan.valid  = 1'b0;
    div_start       = 1'b0;
    restart_run     = 1'b0;
    win_cmd.push    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          x_nxt     = in_chan.sample[SAMPLE_WIDTH-1:0];
          end_nxt   = in_chan.stream_end;
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        win_cmd.push = 1'b1;
        state_nxt    = ST_DECIDE;
      end
      ST_DECIDE: begin
        main_nxt  = emit;
        full_nxt  = full_now;
        flush_nxt = flush_now;
        if (emit && full_now) begin
          div_start = 1'b1;
          state_nxt = ST_DIVIDE;
        end else if (emit || (flush_now != '0)) begin
          state_nxt = ST_SEND;
        end else begin
          restart_run = end_r;
          state_nxt   = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        out_chan.valid = 1'b1;
        if (out_chan.ready) begin
          if (main_r) begin
            main_nxt = 1'b0;
          end else begin
            flush_nxt = flush_r - K_W'(1);
          end
          if (last_one) begin
            restart_run = end_r;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    win_cmd.restart = restart_run | wr_radius;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      end_r   <= 1'b0;
      main_r  <= 1'b0;
      full_r  <= 1'b0;
      flush_r <= '0;
    end else begin
      state_r <= state_nxt;
      end_r   <= end_nxt;
      main_r  <= main_nxt;
      full_r  <= full_nxt;
      flush_r <= flush_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
  end

  // Result payload: the mean for a full window, else -1
  assign out_chan.full_window = main_r & full_r;
  assign out_chan.average     = (main_r && full_r) ? DATA_W'(div_quo) : {DATA_W{1'b1}};
  assign out_chan.run_end     = end_r & last_one;

  // Checks
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen <= win)
    else $error("window fill count above window size");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |-> !out_chan.valid)
    else $error("input taken while a result is pending");

  a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && out_chan.run_end) |=> (seen == '0))
    else $error("stream not restarted after run end");

endmodule

`default_nettype wire
